// ===== hw/rtl/skvb_pkg.sv =====
`default_nettype none
package skvb_pkg;

    localparam int DATA_BYTES_DEF    = 8192;
    localparam int MAX_ENTRIES_DEF   = 1024;
    localparam int MAX_QUERY_KEY_DEF = 256;
    localparam logic [13:0] CAPACITY_RESET = 14'd4096;

    localparam logic [2:0] CMD_KEY_BYTE   = 3'd0;
    localparam logic [2:0] CMD_VALUE_BYTE = 3'd1;
    localparam logic [2:0] CMD_COMMIT     = 3'd2;
    localparam logic [2:0] CMD_QKEY_BYTE  = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic KIND_COMMIT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic [63:0] version;
        logic        force_write;
    } skvb_in_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [12:0] entry_offset;
        logic [9:0]  entry_index;
    } skvb_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_kv_block_versioned_lookup_top.sv =====
// sorted key-value block with versioned lookup
// input channel (in_valid / in_stall, payload in_data) carries one command per transfer:
// entry key byte, entry value byte, commit, query key byte, run query, clear block
// result channel (out_valid / out_stall, payload out_data) carries one result for each
// commit and run query; the other commands give none
// cfg_valid / cfg_ready writes capacity_bytes, the soft limit of the commit test
// byte commands and clear pass through a wait state before the next command is taken
// a commit writes 4 length bytes and 8 version bytes through the single data memory
// write port; the table entry is written with the last of them
// a query runs a sequencer over the data memory, reading one byte at a time;
// the memory read port is the limit
// in_stall is high while a command is in progress or a result waits
// a result stays on out_data until taken; the block takes no command meanwhile
// reset clears counts, pending entry and query key length; memories are not cleared
// capacity_bytes resets to 4096
`default_nettype none
module sorted_kv_block_versioned_lookup_top #(
    parameter int DATA_BYTES    = skvb_pkg::DATA_BYTES_DEF,
    parameter int MAX_ENTRIES   = skvb_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_QUERY_KEY = skvb_pkg::MAX_QUERY_KEY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire skvb_pkg::skvb_in_t in_data,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      skvb_pkg::skvb_out_t out_data,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [13:0]        cfg_data
);
    import skvb_pkg::*;

    localparam int AW = $clog2(DATA_BYTES);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int QW = $clog2(MAX_QUERY_KEY);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int W  = 18;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_WAIT   = 14'b00000000000010,
        S_CWR    = 14'b00000000000100,
        S_RESULT = 14'b00000000001000,
        S_BMID   = 14'b00000000010000,
        S_TRD    = 14'b00000000100000,
        S_HDR    = 14'b00000001000000,
        S_KEY    = 14'b00000010000000,
        S_KEYW   = 14'b00000100000000,
        S_DEC    = 14'b00001000000000,
        S_VL     = 14'b00010000000000,
        S_VER    = 14'b00100000000000,
        S_VERW   = 14'b01000000000000,
        S_HDRW   = 14'b10000000000000
    } state_t;

    // search phase
    typedef enum logic [2:0] {
        P_BIN  = 3'b001,
        P_BACK = 3'b010,
        P_FWD  = 3'b100
    } phase_t;

    logic [7:0]     dmem [DATA_BYTES];
    logic [AW-1:0]  omem [MAX_ENTRIES];
    logic [7:0]     qmem [MAX_QUERY_KEY];

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [13:0] cap_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0] dend_reg, pkl_reg, pvl_reg;
    logic pov_reg;
    logic [QW:0] qkl_reg;
    logic qov_reg;
    skvb_out_t res_reg;
    skvb_in_t cur_reg;

    // data memory port
    logic dm_we;
    logic [W-1:0] dm_wa, dm_ra;
    logic [7:0] dm_wd, dm_rd;
    logic om_we;
    logic [EW-1:0] om_ra;
    logic [AW-1:0] om_rd;
    logic [QW-1:0] qm_ra;
    logic [7:0] qm_rd;

    always_ff @(posedge clk)
    begin
        if (dm_we && dm_wa < W'(DATA_BYTES))
            dmem[dm_wa[AW-1:0]] <= dm_wd;
        dm_rd <= dmem[dm_ra[AW-1:0]];
        if (om_we)
            omem[cnt_reg[EW-1:0]] <= dend_reg[AW-1:0];
        om_rd <= omem[om_ra];
        if (in_valid && !in_stall && in_data.cmd == CMD_QKEY_BYTE
            && qkl_reg < (QW+1)'(MAX_QUERY_KEY))
            qmem[qkl_reg[QW-1:0]] <= in_data.data_byte;
        qm_rd <= qmem[qm_ra];
    end

    // commit / search working registers
    logic [3:0]  wstep_reg;
    logic [W-1:0] left_reg, right_reg, mid_reg, k_reg;
    logic [W-1:0] off_reg, kl_reg, i_reg, pos_reg;
    logic [1:0]  cmpres_reg; // 0 eq, 1 lt, 2 gt
    logic [63:0] ver_reg;
    logic [7:0]  lo_reg;
    logic        found_reg;
    logic [W-1:0] found_k_reg;

    logic accept;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_RESULT);
    assign out_data = res_reg;

    logic [W-1:0] klen_min;
    assign klen_min = (kl_reg < W'(qkl_reg)) ? kl_reg : W'(qkl_reg);

    logic [W-1:0] cur_sz;
    assign cur_sz = dend_reg + W'({cnt_reg, 1'b0}) + W'(2) + pkl_reg + pvl_reg + W'(6);

    always_comb
    begin
        dm_we = 1'b0;
        dm_wa = '0;
        dm_wd = '0;
        dm_ra = pos_reg;
        om_we = 1'b0;
        om_ra = mid_reg[EW-1:0];
        qm_ra = i_reg[QW-1:0];
        if (state_reg == S_IDLE && accept)
        begin
            if (in_data.cmd == CMD_KEY_BYTE && pvl_reg == '0 && !pov_reg)
            begin
                dm_we = 1'b1;
                dm_wa = dend_reg + W'(2) + pkl_reg;
                dm_wd = in_data.data_byte;
            end
            else if (in_data.cmd == CMD_VALUE_BYTE && !pov_reg)
            begin
                dm_we = 1'b1;
                dm_wa = dend_reg + W'(4) + pkl_reg + pvl_reg;
                dm_wd = in_data.data_byte;
            end
        end
        if (state_reg == S_CWR)
        begin
            dm_we = 1'b1;
            case (wstep_reg)
                4'd0: begin dm_wa = dend_reg; dm_wd = pkl_reg[7:0]; end
                4'd1: begin dm_wa = dend_reg + W'(1); dm_wd = 8'(pkl_reg >> 8); end
                4'd2: begin dm_wa = dend_reg + W'(2) + pkl_reg; dm_wd = pvl_reg[7:0]; end
                4'd3: begin dm_wa = dend_reg + W'(3) + pkl_reg; dm_wd = 8'(pvl_reg >> 8); end
                default:
                begin
                    dm_wa = dend_reg + W'(4) + pkl_reg + pvl_reg + W'(wstep_reg - 4'd4);
                    dm_wd = 8'(cur_reg.version >> {wstep_reg - 4'd4, 3'b000});
                end
            endcase
            om_we = (wstep_reg == 4'd11);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_BIN;
            cap_reg <= CAPACITY_RESET;
            cnt_reg <= '0;
            dend_reg <= '0;
            pkl_reg <= '0;
            pvl_reg <= '0;
            pov_reg <= 1'b0;
            qkl_reg <= '0;
            qov_reg <= 1'b0;
            wstep_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                if (accept)
                begin
                    cur_reg <= in_data;
                    state_reg <= S_WAIT;
                    case (in_data.cmd)
                        CMD_KEY_BYTE:
                        if (pvl_reg == '0 && !pov_reg)
                        begin
                            if (dend_reg + W'(2) + pkl_reg >= W'(DATA_BYTES))
                                pov_reg <= 1'b1;
                            else
                                pkl_reg <= pkl_reg + W'(1);
                        end
                        CMD_VALUE_BYTE:
                        if (!pov_reg)
                        begin
                            if (dend_reg + W'(4) + pkl_reg + pvl_reg >= W'(DATA_BYTES))
                                pov_reg <= 1'b1;
                            else
                                pvl_reg <= pvl_reg + W'(1);
                        end
                        CMD_COMMIT:
                        begin
                            res_reg <= '{KIND_COMMIT, ST_OK, '0, '0};
                            if (!in_data.force_write && cnt_reg != '0
                                && cur_sz > W'(cap_reg))
                            begin
                                res_reg.status <= ST_CAPACITY;
                                state_reg <= S_RESULT;
                            end
                            else if (pov_reg || cnt_reg >= CW'(MAX_ENTRIES)
                                || dend_reg + W'(12) + pkl_reg + pvl_reg > W'(DATA_BYTES))
                            begin
                                res_reg.status <= ST_OVERFLOW;
                                state_reg <= S_RESULT;
                            end
                            else
                            begin
                                wstep_reg <= '0;
                                state_reg <= S_CWR;
                            end
                            if (!(!(!in_data.force_write && cnt_reg != '0
                                && cur_sz > W'(cap_reg)) && !(pov_reg
                                || cnt_reg >= CW'(MAX_ENTRIES)
                                || dend_reg + W'(12) + pkl_reg + pvl_reg > W'(DATA_BYTES))))
                            begin
                                pkl_reg <= '0;
                                pvl_reg <= '0;
                                pov_reg <= 1'b0;
                            end
                        end
                        CMD_QKEY_BYTE:
                        if (qkl_reg < (QW+1)'(MAX_QUERY_KEY))
                            qkl_reg <= qkl_reg + 1'b1;
                        else
                            qov_reg <= 1'b1;
                        CMD_QUERY:
                        begin
                            res_reg <= '{KIND_QUERY, ST_NOT_FOUND, '0, '0};
                            found_reg <= 1'b0;
                            left_reg <= '0;
                            right_reg <= W'(cnt_reg) - W'(1);
                            phase_reg <= P_BIN;
                            if (qov_reg)
                            begin
                                res_reg.status <= ST_OVERFLOW;
                                state_reg <= S_RESULT;
                            end
                            else if (cnt_reg == '0)
                                state_reg <= S_RESULT;
                            else
                                state_reg <= S_BMID;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_reg <= '0;
                            dend_reg <= '0;
                            pkl_reg <= '0;
                            pvl_reg <= '0;
                            pov_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_WAIT:
                    state_reg <= S_IDLE;
                S_CWR:
                begin
                    wstep_reg <= wstep_reg + 4'd1;
                    if (wstep_reg == 4'd11)
                    begin
                        res_reg.entry_offset <= 13'(dend_reg);
                        res_reg.entry_index <= 10'(cnt_reg);
                        cnt_reg <= cnt_reg + 1'b1;
                        dend_reg <= dend_reg + W'(12) + pkl_reg + pvl_reg;
                        pkl_reg <= '0;
                        pvl_reg <= '0;
                        pov_reg <= 1'b0;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                if (!out_stall)
                begin
                    state_reg <= S_IDLE;
                    if (res_reg.kind == KIND_QUERY)
                    begin
                        qkl_reg <= '0;
                        qov_reg <= 1'b0;
                    end
                end
                S_BMID:
                begin
                    // mid_reg holds the table index to compare
                    if (phase_reg == P_BIN)
                        mid_reg <= left_reg + ((right_reg - left_reg) >> 1);
                    state_reg <= S_TRD;
                end
                S_TRD:
                begin
                    state_reg <= S_HDR;
                    wstep_reg <= '0;
                end
                S_HDR:
                begin
                    // om_rd valid now; read key length bytes
                    if (wstep_reg == 4'd0)
                    begin
                        off_reg <= W'(om_rd);
                        pos_reg <= W'(om_rd);
                        wstep_reg <= 4'd1;
                    end
                    else if (wstep_reg == 4'd1)
                    begin
                        pos_reg <= pos_reg + W'(1);
                        wstep_reg <= 4'd2;
                    end
                    else if (wstep_reg == 4'd2)
                    begin
                        lo_reg <= dm_rd;
                        wstep_reg <= 4'd3;
                    end
                    else
                    begin
                        kl_reg <= W'({dm_rd, lo_reg});
                        i_reg <= '0;
                        pos_reg <= off_reg + W'(2);
                        state_reg <= S_KEY;
                    end
                end
                S_KEY:
                begin
                    if (i_reg >= klen_min)
                    begin
                        cmpres_reg <= (kl_reg < W'(qkl_reg)) ? 2'd1
                                    : (kl_reg > W'(qkl_reg)) ? 2'd2 : 2'd0;
                        state_reg <= S_DEC;
                    end
                    else
                        state_reg <= S_KEYW;
                end
                S_KEYW:
                begin
                    if (wstep_reg == 4'd3)
                        wstep_reg <= 4'd4;
                    else
                    begin
                        wstep_reg <= 4'd3;
                        if (dm_rd != qm_rd)
                        begin
                            cmpres_reg <= (dm_rd < qm_rd) ? 2'd1 : 2'd2;
                            state_reg <= S_DEC;
                        end
                        else
                        begin
                            i_reg <= i_reg + W'(1);
                            pos_reg <= pos_reg + W'(1);
                            state_reg <= S_KEY;
                        end
                    end
                    if (wstep_reg == 4'd3)
                        state_reg <= S_KEYW;
                end
                S_DEC:
                begin
                    case (phase_reg)
                        P_BIN:
                        if (cmpres_reg == 2'd0)
                        begin
                            k_reg <= mid_reg;
                            if (mid_reg != '0)
                            begin
                                mid_reg <= mid_reg - W'(1);
                                phase_reg <= P_BACK;
                                state_reg <= S_BMID;
                            end
                            else
                                state_reg <= S_HDRW;
                        end
                        else
                        begin
                            if (cmpres_reg == 2'd1)
                            begin
                                left_reg <= mid_reg + W'(1);
                                if (mid_reg + W'(1) > right_reg)
                                    state_reg <= S_RESULT;
                                else
                                    state_reg <= S_BMID;
                            end
                            else
                            begin
                                right_reg <= mid_reg - W'(1);
                                if (mid_reg == left_reg)
                                    state_reg <= S_RESULT;
                                else
                                    state_reg <= S_BMID;
                            end
                        end
                        P_BACK:
                        if (cmpres_reg == 2'd0)
                        begin
                            k_reg <= mid_reg;
                            if (mid_reg != '0)
                            begin
                                mid_reg <= mid_reg - W'(1);
                                state_reg <= S_BMID;
                            end
                            else
                                state_reg <= S_HDRW;
                        end
                        else
                            state_reg <= S_HDRW;
                        default:
                        if (cmpres_reg != 2'd0)
                            state_reg <= S_RESULT;
                        else
                        begin
                            // read value length then version
                            pos_reg <= off_reg + W'(2) + kl_reg;
                            wstep_reg <= '0;
                            state_reg <= S_VL;
                        end
                    endcase
                end
                S_HDRW:
                begin
                    // k_reg is the lowest-index matching entry
                    if (cur_reg.version == 64'd0)
                    begin
                        mid_reg <= k_reg;
                        wstep_reg <= 4'd8;
                        found_reg <= 1'b1;
                        found_k_reg <= k_reg;
                        phase_reg <= P_FWD;
                        state_reg <= S_VERW;
                    end
                    else
                    begin
                        mid_reg <= k_reg;
                        phase_reg <= P_FWD;
                        state_reg <= S_BMID;
                    end
                end
                S_VL:
                begin
                    wstep_reg <= wstep_reg + 4'd1;
                    if (wstep_reg == 4'd0)
                        pos_reg <= pos_reg + W'(1);
                    else if (wstep_reg == 4'd1)
                        lo_reg <= dm_rd;
                    else
                    begin
                        pos_reg <= off_reg + W'(4) + kl_reg + W'({dm_rd, lo_reg});
                        wstep_reg <= '0;
                        state_reg <= S_VER;
                    end
                end
                S_VER:
                begin
                    // issue read at pos, capture next cycle
                    wstep_reg <= wstep_reg;
                    state_reg <= S_VERW;
                    pos_reg <= pos_reg + W'(1);
                end
                S_VERW:
                begin
                    if (found_reg)
                    begin
                        res_reg.status <= ST_OK;
                        res_reg.entry_offset <= 13'(off_reg);
                        res_reg.entry_index <= 10'(found_k_reg);
                        if (wstep_reg == 4'd8)
                        begin
                            state_reg <= S_BMID;
                            found_reg <= 1'b0;
                            wstep_reg <= 4'd9;
                        end
                        else
                            state_reg <= S_RESULT;
                    end
                    else
                    begin
                        ver_reg <= {dm_rd, ver_reg[63:8]};
                        wstep_reg <= wstep_reg + 4'd1;
                        if (wstep_reg == 4'd7)
                        begin
                            if ({dm_rd, ver_reg[63:8]} <= cur_reg.version)
                            begin
                                res_reg.status <= ST_OK;
                                res_reg.entry_offset <= 13'(off_reg);
                                res_reg.entry_index <= 10'(mid_reg);
                                state_reg <= S_RESULT;
                            end
                            else if (mid_reg + W'(1) >= W'(cnt_reg))
                                state_reg <= S_RESULT;
                            else
                            begin
                                mid_reg <= mid_reg + W'(1);
                                state_reg <= S_BMID;
                            end
                        end
                        else
                            state_reg <= S_VER;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            // version 0: fetch offset of k then report it
            if (state_reg == S_HDR && wstep_reg == 4'd0 && found_k_reg == mid_reg
                && phase_reg == P_FWD && cur_reg.version == 64'd0)
            begin
                res_reg.status <= ST_OK;
                res_reg.entry_offset <= 13'(om_rd);
                res_reg.entry_index <= 10'(mid_reg);
                state_reg <= S_RESULT;
            end
        end
    end

    assign state_next = state_reg;

`ifndef SYNTHESIS
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table");
    a_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_next))
        else $error("state not one-hot");
`endif

endmodule
`default_nettype wire

// ===== tb/sorted_kv_block_versioned_lookup_top_tb.sv =====
`timescale 1ns / 1ps

class kv_scoreboard;
    bit [7:0]    mem_bytes[8192];
    bit [12:0]   offsets[1024];
    int unsigned n_entries;
    int unsigned data_end;
    int unsigned pend_klen;
    int unsigned pend_vlen;
    bit          pend_ovf;
    bit [7:0]    qkey[256];
    int unsigned qkey_len;
    bit          qkey_ovf;
    int unsigned capacity;
    skvb_pkg::skvb_out_t results_due[$];
    int          errors;

    function new();
        n_entries = 0;
        data_end = 0;
        pend_klen = 0;
        pend_vlen = 0;
        pend_ovf = 0;
        qkey_len = 0;
        qkey_ovf = 0;
        capacity = 4096;
        errors = 0;
    endfunction

    function int unsigned rd(int unsigned a);
        return (a < 8192) ? int'(mem_bytes[a]) : 0;
    endfunction

    function void wr(int unsigned a, int unsigned v);
        if (a < 8192)
            mem_bytes[a] = v[7:0];
    endfunction

    function int unsigned rd16(int unsigned a);
        return rd(a) | (rd(a + 1) << 8);
    endfunction

    function int key_cmp(int unsigned off);
        int unsigned kl;
        int unsigned n;
        int unsigned a;
        kl = rd16(off);
        n = (kl < qkey_len) ? kl : qkey_len;
        for (int unsigned i = 0; i < n; i++)
        begin
            a = rd(off + 2 + i);
            if (a != qkey[i])
                return (a < qkey[i]) ? -1 : 1;
        end
        if (kl < qkey_len)
            return -1;
        if (kl > qkey_len)
            return 1;
        return 0;
    endfunction

    function bit [63:0] entry_ver(int unsigned off);
        int unsigned kl;
        int unsigned pos;
        bit [63:0] v;
        kl = rd16(off);
        pos = off + 4 + kl + rd16(off + 2 + kl);
        v = '0;
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = rd(pos + i);
        return v;
    endfunction

    function bit [1:0] commit(bit [63:0] ver, bit f, output int unsigned off,
                              output int unsigned idx);
        int unsigned cur;
        off = 0;
        idx = 0;
        cur = data_end + 2 * n_entries + 2;
        if (!f && n_entries != 0 && cur + pend_klen + pend_vlen + 6 > capacity)
            return skvb_pkg::ST_CAPACITY;
        if (pend_ovf || n_entries >= 1024 || data_end + 12 + pend_klen + pend_vlen > 8192)
            return skvb_pkg::ST_OVERFLOW;
        wr(data_end, pend_klen);
        wr(data_end + 1, pend_klen >> 8);
        wr(data_end + 2 + pend_klen, pend_vlen);
        wr(data_end + 3 + pend_klen, pend_vlen >> 8);
        for (int i = 0; i < 8; i++)
            wr(data_end + 4 + pend_klen + pend_vlen + i, ver[8*i +: 8]);
        offsets[n_entries] = data_end;
        off = data_end;
        idx = n_entries;
        n_entries++;
        data_end += 12 + pend_klen + pend_vlen;
        return skvb_pkg::ST_OK;
    endfunction

    function bit [1:0] lookup(bit [63:0] ver, output int unsigned off,
                              output int unsigned idx);
        int lo;
        int hi;
        int mid;
        int hit;
        int c;
        int unsigned k;
        off = 0;
        idx = 0;
        if (qkey_ovf)
            return skvb_pkg::ST_OVERFLOW;
        lo = 0;
        hi = int'(n_entries) - 1;
        hit = -1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            c = key_cmp(offsets[mid]);
            if (c == 0)
            begin
                hit = mid;
                break;
            end
            if (c < 0)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        if (hit < 0)
            return skvb_pkg::ST_NOT_FOUND;
        k = hit;
        while (k > 0 && key_cmp(offsets[k - 1]) == 0)
            k--;
        if (ver == 0)
        begin
            off = offsets[k];
            idx = k;
            return skvb_pkg::ST_OK;
        end
        for (; k < n_entries; k++)
        begin
            if (key_cmp(offsets[k]) != 0)
                break;
            if (entry_ver(offsets[k]) <= ver)
            begin
                off = offsets[k];
                idx = k;
                return skvb_pkg::ST_OK;
            end
        end
        return skvb_pkg::ST_NOT_FOUND;
    endfunction

    function void note_input(skvb_pkg::skvb_in_t it);
        int unsigned pos;
        int unsigned off;
        int unsigned idx;
        skvb_pkg::skvb_out_t r;
        case (it.cmd)
            skvb_pkg::CMD_KEY_BYTE:
            begin
                if (pend_vlen == 0 && !pend_ovf)
                begin
                    pos = data_end + 2 + pend_klen;
                    if (pos >= 8192)
                        pend_ovf = 1;
                    else
                    begin
                        wr(pos, it.data_byte);
                        pend_klen++;
                    end
                end
            end
            skvb_pkg::CMD_VALUE_BYTE:
            begin
                if (!pend_ovf)
                begin
                    pos = data_end + 4 + pend_klen + pend_vlen;
                    if (pos >= 8192)
                        pend_ovf = 1;
                    else
                    begin
                        wr(pos, it.data_byte);
                        pend_vlen++;
                    end
                end
            end
            skvb_pkg::CMD_COMMIT:
            begin
                r.kind = skvb_pkg::KIND_COMMIT;
                r.status = commit(it.version, it.force_write, off, idx);
                r.entry_offset = off[12:0];
                r.entry_index = idx[9:0];
                results_due.push_back(r);
                pend_klen = 0;
                pend_vlen = 0;
                pend_ovf = 0;
            end
            skvb_pkg::CMD_QKEY_BYTE:
            begin
                if (qkey_len < 256)
                begin
                    qkey[qkey_len] = it.data_byte;
                    qkey_len++;
                end
                else
                    qkey_ovf = 1;
            end
            skvb_pkg::CMD_QUERY:
            begin
                r.kind = skvb_pkg::KIND_QUERY;
                r.status = lookup(it.version, off, idx);
                r.entry_offset = off[12:0];
                r.entry_index = idx[9:0];
                results_due.push_back(r);
                qkey_len = 0;
                qkey_ovf = 0;
            end
            skvb_pkg::CMD_CLEAR:
            begin
                n_entries = 0;
                data_end = 0;
                pend_klen = 0;
                pend_vlen = 0;
                pend_ovf = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_result(skvb_pkg::skvb_out_t got);
        skvb_pkg::skvb_out_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result transfer %h", got);
            errors++;
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.entry_offset !== want.entry_offset)
        begin
            $error("entry_offset: expected %0d actual %0d", want.entry_offset,
                   got.entry_offset);
            errors++;
        end
        if (got.entry_index !== want.entry_index)
        begin
            $error("entry_index: expected %0d actual %0d", want.entry_index,
                   got.entry_index);
            errors++;
        end
    endfunction
endclass

module sorted_kv_block_versioned_lookup_top_tb;
    import skvb_pkg::*;

    typedef struct {
        int       len;
        bit [7:0] b[4];
    } key_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    skvb_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    skvb_out_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [13:0] cfg_data;

    kv_scoreboard sb;
    int idle_mode;
    int send_gap_pct;
    int items_sent;
    bit hold_req;
    int hold_left;

    sorted_kv_block_versioned_lookup_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // result side: check transfers, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (idle_mode == 0)
            out_stall <= ($urandom_range(99) < 53);
        else if (idle_mode == 1)
            out_stall <= ($urandom_range(99) < 31);
        else
            out_stall <= 1'b0;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_cmd(logic [2:0] c, logic [7:0] b, logic [63:0] v, logic f);
        skvb_in_t it;
        it.cmd = c;
        it.data_byte = b;
        it.version = v;
        it.force_write = f;
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        items_sent++;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_capacity(logic [13:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.capacity = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_entry(key_t k, int vlen, logic [63:0] ver, logic f);
        for (int i = 0; i < k.len; i++)
            send_cmd(CMD_KEY_BYTE, k.b[i], rand64(), $urandom_range(1));
        for (int i = 0; i < vlen; i++)
            send_cmd(CMD_VALUE_BYTE, $urandom_range(255), rand64(), $urandom_range(1));
        send_cmd(CMD_COMMIT, $urandom_range(255), ver, f);
    endtask

    task automatic send_query(key_t k, logic [63:0] ver);
        for (int i = 0; i < k.len; i++)
            send_cmd(CMD_QKEY_BYTE, k.b[i], rand64(), $urandom_range(1));
        send_cmd(CMD_QUERY, $urandom_range(255), ver, $urandom_range(1));
    endtask

    function automatic key_t mk_key(int len, bit [7:0] b0, bit [7:0] b1);
        key_t k;
        k.len = len;
        k.b[0] = b0;
        k.b[1] = b1;
        k.b[2] = 8'h00;
        k.b[3] = 8'h00;
        return k;
    endfunction

    function automatic bit key_less(key_t a, key_t b);
        int n;
        n = (a.len < b.len) ? a.len : b.len;
        for (int i = 0; i < n; i++)
            if (a.b[i] != b.b[i])
                return a.b[i] < b.b[i];
        return a.len < b.len;
    endfunction

    function automatic key_t rand_key();
        key_t k;
        k.len = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(3))
                0: k.b[i] = 8'h00;
                1: k.b[i] = 8'hff;
                2: k.b[i] = 8'h41 + $urandom_range(1);
                default: k.b[i] = $urandom_range(255);
            endcase
        end
        return k;
    endfunction

    task automatic send_noise();
        logic [2:0] c;
        c = $urandom_range(7);
        if (c == CMD_COMMIT || c == CMD_QUERY || c == CMD_CLEAR || $urandom_range(3) == 0)
            c = 3'd6 + $urandom_range(1);
        send_cmd(c, $urandom_range(255), rand64(), $urandom_range(1));
    endtask

    task automatic random_group();
        key_t keys[8];
        key_t t;
        logic [63:0] vers[8][3];
        int nvers[8];
        int nk;
        logic [63:0] v;
        int j;
        if ($urandom_range(99) < 8)
            send_cmd(CMD_CLEAR, $urandom_range(255), rand64(), $urandom_range(1));
        nk = $urandom_range(1, 6);
        for (int i = 0; i < nk; i++)
            keys[i] = rand_key();
        for (int i = 0; i < nk; i++)
            for (int m = 0; m + 1 < nk - i; m++)
                if (key_less(keys[m + 1], keys[m]))
                begin
                    t = keys[m];
                    keys[m] = keys[m + 1];
                    keys[m + 1] = t;
                end
        for (int i = 0; i < nk; i++)
        begin
            nvers[i] = $urandom_range(1, 3);
            v = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(200, 60000));
            for (int m = 0; m < nvers[i]; m++)
            begin
                vers[i][m] = v;
                send_entry(keys[i], $urandom_range(0, 3), v, ($urandom_range(4) == 0));
                if ($urandom_range(9) == 0)
                    send_noise();
                v = v - $urandom_range(1, 80);
            end
        end
        repeat ($urandom_range(2, 6))
        begin
            j = $urandom_range(nk - 1);
            t = ($urandom_range(4) == 0) ? rand_key() : keys[j];
            case ($urandom_range(4))
                0: v = 64'd0;
                1: v = vers[j][$urandom_range(nvers[j] - 1)];
                2: v = vers[j][$urandom_range(nvers[j] - 1)] - $urandom_range(1, 40);
                3: v = '1;
                default: v = rand64();
            endcase
            send_query(t, v);
        end
    endtask

    task automatic random_phase(int mode, int n_items);
        int start;
        logic [13:0] caps[4];
        wait_idle();
        idle_mode = mode;
        send_gap_pct = (mode == 0) ? 31 : (mode == 1) ? 53 : 0;
        caps[0] = 14'd1;
        caps[1] = 14'd8192;
        caps[2] = $urandom_range(1, 8192);
        caps[3] = $urandom_range(100, 600);
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(9) == 0)
                write_capacity(caps[$urandom_range(3)]);
            if (mode == 0 && items_sent - start > n_items / 2 && hold_left == 0 &&
                $urandom_range(19) == 0)
                hold_req = 1;
            random_group();
        end
    endtask

    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        key_t ka;
        key_t kb;
        key_t kz;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_mode = 2;
        send_gap_pct = 0;
        items_sent = 0;
        hold_req = 0;
        hold_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part
        ka = mk_key(1, 8'h41, 8'h00);
        kb = mk_key(2, 8'hff, 8'hff);
        kz = mk_key(0, 8'h00, 8'h00);
        send_query(ka, 64'd0);
        send_entry(kz, 0, 64'd7, 1'b0);
        send_entry(mk_key(1, 8'h00, 8'h00), 1, 64'd1, 1'b0);
        send_entry(ka, 2, 64'd9, 1'b0);
        send_entry(ka, 0, 64'd5, 1'b0);
        send_entry(ka, 1, 64'd2, 1'b0);
        // key byte after value byte is dropped
        send_cmd(CMD_KEY_BYTE, 8'hff, '1, 1'b1);
        send_cmd(CMD_VALUE_BYTE, 8'h00, '0, 1'b0);
        send_cmd(CMD_KEY_BYTE, 8'hff, '0, 1'b0);
        send_cmd(CMD_KEY_BYTE, 8'hff, '0, 1'b0);
        send_cmd(CMD_COMMIT, 8'h00, '1, 1'b0);
        send_cmd(3'd6, 8'hff, '1, 1'b1);
        send_cmd(3'd7, 8'h00, '0, 1'b0);
        send_query(ka, 64'd0);
        send_query(ka, 64'd6);
        send_query(ka, 64'd1);
        send_query(ka, '1);
        send_query(kz, 64'd0);
        send_query(kb, 64'd3);
        // query key too long
        repeat (257)
            send_cmd(CMD_QKEY_BYTE, 8'h41, '0, 1'b0);
        send_cmd(CMD_QUERY, 8'h00, 64'd0, 1'b0);
        send_query(ka, 64'd0);
        write_capacity(14'd1);
        send_entry(kb, 1, 64'd4, 1'b0);
        send_entry(kb, 1, 64'd4, 1'b1);
        write_capacity(14'd8192);
        send_cmd(CMD_CLEAR, 8'h00, '0, 1'b0);
        send_query(ka, 64'd0);
        // entry bytes running past the end of memory
        send_entry(kz, 8200, 64'd3, 1'b1);
        send_entry(kz, 8180, '1, 1'b1);
        send_entry(kz, 0, 64'd1, 1'b1);
        send_query(kz, 64'd0);
        send_cmd(CMD_CLEAR, 8'h00, '0, 1'b0);
        write_capacity(14'd4096);

        random_phase(0, 230);
        random_phase(1, 230);
        random_phase(2, 230);

        wait_idle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
